>>> rtl/pol_pkg.sv
// Package: sizes, command and status codes and sequencer states of the ordered list.
`default_nettype none

package pol_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int FIELD_W = 6;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WIDE_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_END   = 3'd4,
        CMD_REM_POS   = 3'd5,
        CMD_CLEAR     = 3'd6,
        CMD_DUMP      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/pol_if.sv
// Interfaces: command channel and result channel of the ordered list.
`default_nettype none

interface pol_cmd_if
    import pol_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [2:0]               command;
    logic signed [DATA_W-1:0] code_value;
    logic [FIELD_W-1:0]       position;

    modport source (output valid, command, code_value, position, input ready);
    modport sink   (input valid, command, code_value, position, output ready);
endinterface

interface pol_res_if
    import pol_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic [FIELD_W-1:0]       element_index;
    logic [FIELD_W-1:0]       list_count;
    logic                     last;

    modport source (output valid, status, element, element_index, list_count, last,
                    input ready);
    modport sink   (input valid, status, element, element_index, list_count, last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pol_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wa,
    input  wire logic [WIDTH-1:0]         wd,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] ra,
    output logic      [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd <= mem[ra];
        end
    end

endmodule

`default_nettype wire

>>> rtl/positional_ordered_list.sv
// Top level: bounded ordered list of signed codes kept in a RAM, with a shift sequencer.
//
// Usage. Commands arrive on the cmd channel (valid/ready, one beat per command):
// insert front/end/at position, remove front/end/at position, clear, dump.
// Results leave on the res channel, one beat per result; every command gives one
// beat except a dump of a non-empty list, which gives one beat per element in
// order, with last high on the final beat of each command.
// The list lives in one RAM of DEPTH words (one write port, one registered read
// port). Inserts and removes move every element behind the touched slot by one
// place, one read and one write per element; an insert then writes the new code to
// its slot, a remove first reads out the removed element, and a dump reads and
// outputs each element in turn; clear and status-only results go straight out.
// One command is in work at a time; cmd.ready is high only while the sequencer
// is idle. The result register decouples the two sides: a new command is taken
// while the previous result still waits, and the sequencer holds its final step
// until the result register is free.
// Reset (rst_n low, asynchronous) empties the list and drops any pending result;
// RAM contents are not cleared and are never read before being written.
// A stalled receiver (res.ready low) holds the result beat stable and stalls the
// sequencer; no beat is lost or repeated.
`default_nettype none

module positional_ordered_list
    import pol_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pol_cmd_if.sink   cmd,
    pol_res_if.source res
);

    // sequencer state and working registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   at_reg, at_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  elem_reg, elem_next;
    status_t            stat_reg, stat_next;
    logic               first_reg, first_next;

    // result register
    logic               res_valid_reg;
    status_t            res_stat_reg;
    logic [DATA_W-1:0]  res_elem_reg;
    logic [FIELD_W-1:0] res_index_reg;
    logic [FIELD_W-1:0] res_count_reg;
    logic               res_last_reg;

    // result load from the sequencer
    logic               out_free;
    logic               out_load;
    status_t            load_stat;
    logic [DATA_W-1:0]  load_elem;
    logic [FIELD_W-1:0] load_index;
    logic               load_last;

    // RAM port
    logic               ram_we;
    logic [CNT_W-1:0]   ram_wa_wide;
    logic [DATA_W-1:0]  ram_wd;
    logic               ram_re;
    logic [CNT_W-1:0]   ram_ra_wide;
    logic [DATA_W-1:0]  ram_rd;

    // command decode
    cmd_t               dec_cmd;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic               pos_ok;
    logic [CNT_W-1:0]   pos_at;
    logic [CNT_W-1:0]   idx_plus;
    logic [CNT_W-1:0]   idx_minus;
    state_t             dec_state;
    status_t            dec_status;
    logic [CNT_W-1:0]   dec_at;
    logic [CNT_W-1:0]   dec_idx;

    assign dec_cmd   = cmd_t'(cmd.command);
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign is_full   = (count_reg >= CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign pos_ok    = (cmd.position != '0) &&
                       (WIDE_W'(cmd.position) <= WIDE_W'(count_reg));
    assign pos_at    = CNT_W'(cmd.position) - CNT_W'(1);
    assign idx_plus  = idx_reg + CNT_W'(1);
    assign idx_minus = idx_reg - CNT_W'(1);
    assign out_free  = !res_valid_reg || res.ready;

    pol_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk (clk),
        .we  (ram_we),
        .wa  (ram_wa_wide[ADDR_W-1:0]),
        .wd  (ram_wd),
        .re  (ram_re),
        .ra  (ram_ra_wide[ADDR_W-1:0]),
        .rd  (ram_rd)
    );

    // Decode an incoming command: where to go, what status, which slot.
    always_comb
    begin
        dec_state  = S_RESULT;
        dec_status = STAT_OK;
        dec_at     = '0;
        dec_idx    = '0;
        unique case (dec_cmd)
            CMD_INS_FRONT, CMD_INS_END:
            begin
                dec_at  = (dec_cmd == CMD_INS_FRONT) ? '0 : count_reg;
                dec_idx = count_reg;
                if (is_full)
                begin
                    dec_status = STAT_FULL;
                end
                else
                begin
                    dec_state = (dec_at == count_reg) ? S_INS_PUT : S_INS_RD;
                end
            end
            CMD_INS_POS:
            begin
                dec_at  = pos_at;
                dec_idx = count_reg;
                if (!pos_ok)
                begin
                    dec_status = STAT_INVALID;
                end
                else if (is_full)
                begin
                    dec_status = STAT_FULL;
                end
                else
                begin
                    dec_state = S_INS_RD;
                end
            end
            CMD_REM_FRONT, CMD_REM_END, CMD_REM_POS:
            begin
                if (dec_cmd == CMD_REM_FRONT)
                begin
                    dec_at = '0;
                end
                else if (dec_cmd == CMD_REM_END)
                begin
                    dec_at = count_reg - CNT_W'(1);
                end
                else
                begin
                    dec_at = pos_at;
                end
                dec_idx = dec_at;
                if (is_empty)
                begin
                    dec_status = STAT_EMPTY;
                end
                else if (dec_cmd == CMD_REM_POS && !pos_ok)
                begin
                    dec_status = STAT_INVALID;
                end
                else
                begin
                    dec_state = S_REM_RD;
                end
            end
            CMD_CLEAR:
            begin
                dec_status = STAT_OK;
            end
            CMD_DUMP:
            begin
                if (is_empty)
                begin
                    dec_status = STAT_EMPTY;
                end
                else
                begin
                    dec_state = S_DUMP_RD;
                end
            end
            default:
            begin
                dec_state = S_RESULT;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     state_next = accept ? dec_state : S_IDLE;
            S_INS_RD:   state_next = S_INS_WR;
            S_INS_WR:   state_next = (idx_minus == at_reg) ? S_INS_PUT : S_INS_RD;
            S_INS_PUT:  state_next = S_RESULT;
            S_REM_RD:   state_next = S_REM_WR;
            S_REM_WR:   state_next = (idx_plus < count_reg) ? S_REM_RD : S_RESULT;
            S_DUMP_RD:  state_next = S_DUMP_OUT;
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    state_next = (idx_plus == count_reg) ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESULT:   state_next = out_free ? S_IDLE : S_RESULT;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM port and result load.
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        at_next     = at_reg;
        val_next    = val_reg;
        elem_next   = elem_reg;
        stat_next   = stat_reg;
        first_next  = first_reg;
        ram_we      = 1'b0;
        ram_wa_wide = idx_reg;
        ram_wd      = ram_rd;
        ram_re      = 1'b0;
        ram_ra_wide = idx_reg;
        out_load    = 1'b0;
        load_stat   = stat_reg;
        load_elem   = elem_reg;
        load_index  = '0;
        load_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next   = cmd.code_value;
                    at_next    = dec_at;
                    idx_next   = dec_idx;
                    stat_next  = dec_status;
                    elem_next  = '0;
                    first_next = 1'b1;
                    if (dec_cmd == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            S_INS_RD:
            begin
                // fetch the element that moves one place back
                ram_re      = 1'b1;
                ram_ra_wide = idx_minus;
            end
            S_INS_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_minus;
            end
            S_INS_PUT:
            begin
                ram_we      = 1'b1;
                ram_wa_wide = at_reg;
                ram_wd      = val_reg;
                count_next  = count_reg + CNT_W'(1);
            end
            S_REM_RD:
            begin
                ram_re = 1'b1;
            end
            S_REM_WR:
            begin
                // first read is the removed element; later reads move forward
                if (first_reg)
                begin
                    elem_next  = ram_rd;
                    first_next = 1'b0;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_wa_wide = idx_minus;
                end
                idx_next = idx_plus;
                if (!(idx_plus < count_reg))
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_DUMP_RD:
            begin
                ram_re = 1'b1;
            end
            S_DUMP_OUT:
            begin
                load_stat  = STAT_OK;
                load_elem  = ram_rd;
                load_index = FIELD_W'(idx_plus);
                load_last  = (idx_plus == count_reg);
                if (out_free)
                begin
                    out_load = 1'b1;
                    idx_next = idx_plus;
                end
            end
            S_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        at_reg    <= at_next;
        val_reg   <= val_next;
        elem_reg  <= elem_next;
        stat_reg  <= stat_next;
        first_reg <= first_next;
    end

    // Result register: load when free, drop the valid once the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_stat_reg  <= load_stat;
            res_elem_reg  <= load_elem;
            res_index_reg <= load_index;
            res_count_reg <= FIELD_W'(count_reg);
            res_last_reg  <= load_last;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = res_stat_reg;
    assign res.element       = res_elem_reg;
    assign res.element_index = res_index_reg;
    assign res.list_count    = res_count_reg;
    assign res.last          = res_last_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    // The RAM is only written while a command is in work.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("RAM write while idle");

    // Writes stay inside the store.
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_wa_wide < CNT_W'(DEPTH)))
        else $error("RAM write address out of range");

    // A dump only reads live elements.
    a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP_RD) |-> (idx_reg < count_reg))
        else $error("dump read beyond the list");

    // A clear empties the list on the next cycle.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.command == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the list");

endmodule

`default_nettype wire
